FILE: rtl/core/trds_pkg.sv
// ---------------------------------------------------------------------------
// trds_pkg
// shared constants, command and status types of the triangle rasterizer
// ---------------------------------------------------------------------------
package trds_pkg;

    localparam int DISP_W   = 32;
    localparam int DISP_H   = 32;
    localparam int ROW_COLS = (DISP_W < 32) ? DISP_W : 32;
    localparam int DEPTH_N  = DISP_W * DISP_H;
    localparam int ADDR_W   = $clog2(DEPTH_N);
    localparam int X_W      = 6;
    localparam int E_W      = 36;
    localparam int ACC_W    = 62;
    localparam int DVS_W    = 34;
    localparam int Z_W      = 24;

    localparam logic [Z_W-1:0] INV_MAX = 24'hFFFFFF;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ROW    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] SLOT_NONE = 2'd3;

    localparam logic [2:0] MK_NONE   = 3'd0;
    localparam logic [2:0] MK_AREA_A = 3'd1;
    localparam logic [2:0] MK_AREA_B = 3'd2;
    localparam logic [2:0] MK_EDGE_A = 3'd3;
    localparam logic [2:0] MK_EDGE_B = 3'd4;
    localparam logic [2:0] MK_ZW     = 3'd5;
    localparam logic [2:0] MK_CW     = 3'd6;

    localparam logic [2:0] ACC_HOLD  = 3'd0;
    localparam logic [2:0] ACC_LOAD  = 3'd1;
    localparam logic [2:0] ACC_ADD   = 3'd2;
    localparam logic [2:0] ACC_SUB   = 3'd3;
    localparam logic [2:0] ACC_UNIT  = 3'd4;

    localparam logic [1:0] DK_INV    = 2'd0;
    localparam logic [1:0] DK_Z      = 2'd1;
    localparam logic [1:0] DK_COL    = 2'd2;

    typedef struct packed {
        logic [2:0] mkind;
        logic [1:0] midx;
        logic [1:0] chan;
        logic [2:0] acc_op;
        logic [1:0] div_kind;
        logic       div_start;
        logic       vtx_we;
        logic       row_we;
        logic       area_we;
        logic       edge_we;
        logic       inv_we;
        logic       inv_sat;
        logic       x_load;
        logic       x_step;
        logic       mem_rd;
        logic       mem_we;
        logic       clr_we;
        logic       col_we;
        logic       pend_load;
        logic       pend_clr;
        logic       out_pend;
        logic       out_empty;
        logic       out_last;
    } trds_cmd_t;

    typedef struct packed {
        logic       area_pos;
        logic       row_in_box;
        logic       x_lt_xmax;
        logic       in_tri;
        logic [2:0] inv_small;
        logic       div_done;
        logic       depth_win;
        logic       pend_valid;
        logic       out_free;
        logic       clr_last;
    } trds_stat_t;

    function automatic logic [1:0] nxt(input logic [1:0] k);
        logic [1:0] r;
        case (k)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/triangle_rasterizer_depth_shade.sv
// ---------------------------------------------------------------------------
// triangle_rasterizer_depth_shade
// one-row triangle rasterizer with inverse-depth test and gouraud shading
// ---------------------------------------------------------------------------
// A depth clear, which also runs once after reset, writes one entry of the
// depth store per cycle; no item is accepted during a clear. A row command
// runs edge and area setup, then up to three vertex inverse depths on the
// shared serial divider (24 steps each), then walks the bounding box columns;
// each drawn pixel takes a depth division, three 8-step colour divisions
// and one depth store read-modify-write. Results leave through an output
// register, so a new item is taken while the last result of a row still
// waits.
module triangle_rasterizer_depth_shade
    import trds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // vertex_slot, pos_x, pos_y, depth, red, green, blue, row
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pix_x, pix_y, red, green, blue
    output logic        m_tuser,   // pixel_valid
    output logic        m_tlast
);

    trds_cmd_t  cmd;
    trds_stat_t stat;
    logic [4:0] pix_x, pix_y;
    logic [7:0] red_out, green_out, blue_out;

    trds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_slot  (s_tdata[1:0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    trds_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .vertex_slot (s_tdata[1:0]),
        .pos_x       (s_tdata[17:2]),
        .pos_y       (s_tdata[33:18]),
        .depth       (s_tdata[49:34]),
        .red_in      (s_tdata[57:50]),
        .green_in    (s_tdata[65:58]),
        .blue_in     (s_tdata[73:66]),
        .row         (s_tdata[78:74]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .pixel_valid (m_tuser),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .last        (m_tlast)
    );

    assign m_tdata = {6'd0, blue_out, green_out, red_out, pix_y, pix_x};

endmodule

FILE: rtl/core/trds_ctrl.sv
// ---------------------------------------------------------------------------
// trds_ctrl
// sequencer: clear sweep, triangle setup, row walk and result hand-off
// ---------------------------------------------------------------------------
module trds_ctrl
    import trds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_op,
    input  logic [1:0] in_slot,
    output logic       in_ready,
    input  trds_stat_t stat,
    output trds_cmd_t  cmd
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_AREA     = 4'd2;
    localparam logic [3:0] ST_CHECK    = 4'd3;
    localparam logic [3:0] ST_EDGE     = 4'd4;
    localparam logic [3:0] ST_INV      = 4'd5;
    localparam logic [3:0] ST_INV_WAIT = 4'd6;
    localparam logic [3:0] ST_TEST     = 4'd7;
    localparam logic [3:0] ST_NEXT     = 4'd8;
    localparam logic [3:0] ST_Z        = 4'd9;
    localparam logic [3:0] ST_Z_WAIT   = 4'd10;
    localparam logic [3:0] ST_COL      = 4'd11;
    localparam logic [3:0] ST_COL_WAIT = 4'd12;
    localparam logic [3:0] ST_EMIT     = 4'd13;
    localparam logic [3:0] ST_FINISH   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_op)
                        OP_LOAD:  cmd.vtx_we = (in_slot != SLOT_NONE);
                        OP_ROW:
                        begin
                            cmd.row_we = 1'b1;
                            state_next = ST_AREA;
                            step_next  = '0;
                        end
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  ;
                    endcase
                end
            end
            ST_AREA:
            begin
                case (step_reg)
                    3'd0: cmd.mkind = MK_AREA_A;
                    3'd1:
                    begin
                        cmd.mkind  = MK_AREA_B;
                        cmd.acc_op = ACC_LOAD;
                    end
                    3'd2: cmd.acc_op = ACC_SUB;
                    default: cmd.area_we = 1'b1;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.area_pos && stat.row_in_box)
                begin
                    cmd.x_load = 1'b1;
                    state_next = ST_EDGE;
                    step_next  = '0;
                    idx_next   = '0;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_EDGE:
            begin
                cmd.midx = idx_reg;
                case (step_reg)
                    3'd0: cmd.mkind = MK_EDGE_A;
                    3'd1:
                    begin
                        cmd.mkind  = MK_EDGE_B;
                        cmd.acc_op = ACC_LOAD;
                    end
                    3'd2: cmd.acc_op = ACC_SUB;
                    default: cmd.edge_we = 1'b1;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    step_next = '0;
                    if (idx_reg == 2'd2)
                    begin
                        idx_next   = '0;
                        state_next = ST_INV;
                    end
                    else
                        idx_next = idx_reg + 2'd1;
                end
            end
            ST_INV:
            begin
                cmd.midx     = idx_reg;
                cmd.div_kind = DK_INV;
                if (step_reg == 3'd0)
                begin
                    if (stat.inv_small[idx_reg])
                    begin
                        cmd.inv_sat = 1'b1;
                        if (idx_reg == 2'd2)
                            state_next = ST_TEST;
                        else
                            idx_next = idx_reg + 2'd1;
                    end
                    else
                    begin
                        cmd.acc_op = ACC_UNIT;
                        step_next  = 3'd1;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_INV_WAIT;
                end
            end
            ST_INV_WAIT:
            begin
                cmd.midx = idx_reg;
                if (stat.div_done)
                begin
                    cmd.inv_we = 1'b1;
                    step_next  = '0;
                    if (idx_reg == 2'd2)
                        state_next = ST_TEST;
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_INV;
                    end
                end
            end
            ST_TEST:
            begin
                step_next = '0;
                idx_next  = '0;
                if (!stat.x_lt_xmax)
                    state_next = ST_FINISH;
                else if (stat.in_tri)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_Z;
                end
                else
                    state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                cmd.x_step = 1'b1;
                state_next = ST_TEST;
            end
            ST_Z, ST_COL:
            begin
                cmd.chan     = idx_reg;
                cmd.midx     = step_reg[1:0];
                cmd.div_kind = (state_reg == ST_Z) ? DK_Z : DK_COL;
                if (step_reg < 3'd3)
                    cmd.mkind = (state_reg == ST_Z) ? MK_ZW : MK_CW;
                case (step_reg)
                    3'd0: cmd.acc_op = ACC_HOLD;
                    3'd1: cmd.acc_op = ACC_LOAD;
                    3'd4: cmd.div_start = 1'b1;
                    default: cmd.acc_op = ACC_ADD;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                    state_next = (state_reg == ST_Z) ? ST_Z_WAIT : ST_COL_WAIT;
            end
            ST_Z_WAIT:
            begin
                step_next = '0;
                if (stat.div_done)
                begin
                    if (stat.depth_win)
                    begin
                        cmd.mem_we = 1'b1;
                        idx_next   = '0;
                        state_next = ST_COL;
                    end
                    else
                        state_next = ST_NEXT;
                end
            end
            ST_COL_WAIT:
            begin
                cmd.chan  = idx_reg;
                step_next = '0;
                if (stat.div_done)
                begin
                    cmd.col_we = 1'b1;
                    if (idx_reg == 2'd2)
                        state_next = ST_EMIT;
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_COL;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!stat.pend_valid)
                begin
                    cmd.pend_load = 1'b1;
                    state_next    = ST_NEXT;
                end
                else if (stat.out_free)
                begin
                    cmd.out_pend  = 1'b1;
                    cmd.pend_load = 1'b1;
                    state_next    = ST_NEXT;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_last  = 1'b1;
                    cmd.out_pend  = stat.pend_valid;
                    cmd.out_empty = !stat.pend_valid;
                    cmd.pend_clr  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/core/trds_datapath.sv
// ---------------------------------------------------------------------------
// trds_datapath
// vertex store, multiplier and accumulator, serial divider, depth store
// ---------------------------------------------------------------------------
module trds_datapath
    import trds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  trds_cmd_t   cmd,
    output trds_stat_t  stat,
    input  logic [1:0]  vertex_slot,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [15:0] depth,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [4:0]  row,
    input  logic        out_ready,
    output logic        out_valid,
    output logic        pixel_valid,
    output logic [4:0]  pix_x,
    output logic [4:0]  pix_y,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic        last
);

    logic [15:0] vx_reg [3];
    logic [15:0] vy_reg [3];
    logic [15:0] vd_reg [3];
    logic [23:0] vc_reg [3];

    logic [4:0]            row_reg;
    logic [X_W-1:0]        x_reg;
    logic signed [E_W-1:0] area_reg;
    logic signed [E_W-1:0] e_reg [3];
    logic [Z_W-1:0]        inv_reg [3];
    logic [7:0]            cr_reg [3];

    logic signed [24:0]    ma;
    logic signed [34:0]    mb;
    logic signed [59:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic [4:0]       div_cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [23:0]      low_reg;
    logic [Z_W-1:0]   quot_reg;
    logic [DVS_W:0]   div_cand;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] pix_addr;
    logic [Z_W-1:0]    zmem [DEPTH_N];
    logic [Z_W-1:0]    mem_q_reg;

    logic       pend_valid_reg;
    logic [4:0] pend_x_reg;
    logic [7:0] pend_c_reg [3];

    logic       out_valid_reg;
    logic       out_pv_reg;
    logic       out_last_reg;
    logic [4:0] out_x_reg;
    logic [4:0] out_y_reg;
    logic [7:0] out_c_reg [3];

    logic [1:0] k;
    logic [1:0] m;
    logic signed [E_W-1:0] w [3];
    logic signed [E_W-1:0] de [3];
    logic signed [17:0] py_s;
    logic signed [17:0] px_s;

    logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [11:0] fl_x, fl_y;
    logic signed [16:0] hx15, hy15;
    logic signed [12:0] ce_x, ce_y, row_s;
    logic [X_W-1:0]     xmax_c, xmin_c;

    function automatic logic signed [16:0] sd(input logic [15:0] a, input logic [15:0] b);
        return $signed({a[15], a}) - $signed({b[15], b});
    endfunction

    function automatic logic signed [15:0] smin(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [15:0] smax(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        return (a > b) ? a : b;
    endfunction

    assign k = cmd.midx;
    assign m = nxt(cmd.midx);

    assign w[0] = e_reg[1];
    assign w[1] = e_reg[2];
    assign w[2] = e_reg[0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            de[i] = E_W'($signed({sd(vy_reg[nxt(2'(i))], vy_reg[i]), 4'd0}));
    end

    assign py_s = $signed({9'd0, row_reg, 4'd0});
    assign px_s = $signed({8'd0, x_reg, 4'd0});

    // bounding box
    assign lo_x = smin(smin($signed(vx_reg[0]), $signed(vx_reg[1])), $signed(vx_reg[2]));
    assign hi_x = smax(smax($signed(vx_reg[0]), $signed(vx_reg[1])), $signed(vx_reg[2]));
    assign lo_y = smin(smin($signed(vy_reg[0]), $signed(vy_reg[1])), $signed(vy_reg[2]));
    assign hi_y = smax(smax($signed(vy_reg[0]), $signed(vy_reg[1])), $signed(vy_reg[2]));
    assign fl_x = 12'(lo_x >>> 4);
    assign fl_y = 12'(lo_y >>> 4);
    assign hx15 = $signed({hi_x[15], hi_x}) + 17'sd15;
    assign hy15 = $signed({hi_y[15], hi_y}) + 17'sd15;
    assign ce_x = 13'(hx15 >>> 4);
    assign ce_y = 13'(hy15 >>> 4);
    assign row_s = $signed({8'd0, row_reg});

    always_comb
    begin
        if (fl_x < 12'sd0)
            xmin_c = '0;
        else if (fl_x > 12'sd32)
            xmin_c = X_W'(32);
        else
            xmin_c = fl_x[X_W-1:0];
        if (ce_x < 13'sd0)
            xmax_c = '0;
        else if (ce_x > 13'(ROW_COLS))
            xmax_c = X_W'(ROW_COLS);
        else
            xmax_c = ce_x[X_W-1:0];
    end

    // multiplier operands
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.mkind)
            MK_AREA_A:
            begin
                ma = 25'(sd(vx_reg[1], vx_reg[0]));
                mb = 35'(sd(vy_reg[2], vy_reg[0]));
            end
            MK_AREA_B:
            begin
                ma = 25'(sd(vx_reg[2], vx_reg[0]));
                mb = 35'(sd(vy_reg[1], vy_reg[0]));
            end
            MK_EDGE_A:
            begin
                ma = 25'(sd(vx_reg[m], vx_reg[k]));
                mb = 35'(py_s - $signed({{2{vy_reg[k][15]}}, vy_reg[k]}));
            end
            MK_EDGE_B:
            begin
                ma = 25'(sd(vy_reg[m], vy_reg[k]));
                mb = 35'(px_s - $signed({{2{vx_reg[k][15]}}, vx_reg[k]}));
            end
            MK_ZW:
            begin
                ma = $signed({1'b0, inv_reg[k]});
                mb = w[k][34:0];
            end
            MK_CW:
            begin
                case (cmd.chan)
                    2'd0:    ma = $signed({17'd0, vc_reg[k][23:16]});
                    2'd1:    ma = $signed({17'd0, vc_reg[k][15:8]});
                    default: ma = $signed({17'd0, vc_reg[k][7:0]});
                endcase
                mb = w[k][34:0];
            end
            default: ;
        endcase
    end

    assign div_cand = {rem_reg, low_reg[23]};
    assign pix_addr = ADDR_W'(row_reg) * ADDR_W'(DISP_W) + ADDR_W'(x_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
                vd_reg[i] <= '0;
                vc_reg[i] <= '0;
            end
            clr_cnt_reg    <= '0;
            div_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.vtx_we)
            begin
                vx_reg[vertex_slot] <= pos_x;
                vy_reg[vertex_slot] <= pos_y;
                vd_reg[vertex_slot] <= depth;
                vc_reg[vertex_slot] <= {red_in, green_in, blue_in};
            end
            if (cmd.clr_we)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.div_start)
                div_cnt_reg <= (cmd.div_kind == DK_COL) ? 5'd8 : 5'd24;
            else if (div_cnt_reg != 5'd0)
                div_cnt_reg <= div_cnt_reg - 5'd1;
            if (cmd.pend_clr)
                pend_valid_reg <= 1'b0;
            else if (cmd.pend_load)
                pend_valid_reg <= 1'b1;
            if (cmd.out_pend || cmd.out_empty)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        if (cmd.row_we)
            row_reg <= row;
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= ACC_W'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            ACC_SUB:  acc_reg <= acc_reg - ACC_W'(prod_reg);
            ACC_UNIT: acc_reg <= ACC_W'(1) <<< 24;
            default:  ;
        endcase
        if (cmd.area_we)
            area_reg <= acc_reg[E_W-1:0];
        if (cmd.edge_we)
            e_reg[k] <= acc_reg[E_W-1:0];
        if (cmd.x_load)
            x_reg <= xmin_c;
        if (cmd.x_step)
        begin
            x_reg <= x_reg + 1'b1;
            for (int i = 0; i < 3; i++)
                e_reg[i] <= e_reg[i] - de[i];
        end
        if (cmd.inv_sat)
            inv_reg[k] <= INV_MAX;
        else if (cmd.inv_we)
            inv_reg[k] <= quot_reg;
        if (cmd.col_we)
            cr_reg[cmd.chan] <= quot_reg[7:0];

        if (cmd.div_start)
        begin
            quot_reg <= '0;
            if (cmd.div_kind == DK_INV)
                dvs_reg <= DVS_W'(vd_reg[k]);
            else
                dvs_reg <= area_reg[DVS_W-1:0];
            if (cmd.div_kind == DK_COL)
            begin
                rem_reg <= acc_reg[41:8];
                low_reg <= {acc_reg[7:0], 16'd0};
            end
            else
            begin
                rem_reg <= acc_reg[57:24];
                low_reg <= acc_reg[23:0];
            end
        end
        else if (div_cnt_reg != 5'd0)
        begin
            low_reg <= {low_reg[22:0], 1'b0};
            if (div_cand >= {1'b0, dvs_reg})
            begin
                rem_reg  <= DVS_W'(div_cand - {1'b0, dvs_reg});
                quot_reg <= {quot_reg[Z_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= div_cand[DVS_W-1:0];
                quot_reg <= {quot_reg[Z_W-2:0], 1'b0};
            end
        end

        if (cmd.pend_load)
        begin
            pend_x_reg <= x_reg[4:0];
            for (int i = 0; i < 3; i++)
                pend_c_reg[i] <= cr_reg[i];
        end
        if (cmd.out_pend || cmd.out_empty)
        begin
            out_pv_reg   <= cmd.out_pend;
            out_last_reg <= cmd.out_last;
            out_x_reg    <= cmd.out_pend ? pend_x_reg : 5'd0;
            out_y_reg    <= cmd.out_pend ? row_reg : 5'd0;
            for (int i = 0; i < 3; i++)
                out_c_reg[i] <= cmd.out_pend ? pend_c_reg[i] : 8'd0;
        end
    end

    // depth store
    always_ff @(posedge clk)
    begin
        if (cmd.clr_we)
            zmem[clr_cnt_reg] <= '0;
        else if (cmd.mem_we)
            zmem[pix_addr] <= quot_reg;
        if (cmd.mem_rd)
            mem_q_reg <= zmem[pix_addr];
    end

    always_comb
    begin
        stat.area_pos   = !area_reg[E_W-1] && (area_reg != '0);
        stat.row_in_box = (row_s >= 13'(fl_y)) && (row_s < ce_y) && (row_s < 13'(DISP_H));
        stat.x_lt_xmax  = x_reg < xmax_c;
        stat.in_tri     = !e_reg[0][E_W-1] && !e_reg[1][E_W-1] && !e_reg[2][E_W-1];
        for (int i = 0; i < 3; i++)
            stat.inv_small[i] = vd_reg[i] <= 16'd1;
        stat.div_done   = div_cnt_reg == 5'd0;
        stat.depth_win  = quot_reg > mem_q_reg;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = !out_valid_reg || out_ready;
        stat.clr_last   = clr_cnt_reg == ADDR_W'(DEPTH_N - 1);
    end

    assign out_valid   = out_valid_reg;
    assign pixel_valid = out_pv_reg;
    assign pix_x       = out_x_reg;
    assign pix_y       = out_y_reg;
    assign red_out     = out_c_reg[0];
    assign green_out   = out_c_reg[1];
    assign blue_out    = out_c_reg[2];
    assign last        = out_last_reg;

endmodule
